FILE: sv/pcph_pkg.sv
// Shared types and constants for the play count heap.
`timescale 1ns / 1ps
package pcph_pkg;
    localparam int ID_W    = 8;
    localparam int SLOT_W  = 8;
    localparam int SIZE_W  = 9;
    localparam int CNT_W   = 32;
    localparam int DEPTH   = 256;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [SIZE_W-1:0] SIZE_FULL = SIZE_W'(DEPTH);
    localparam logic REQ_RECORD  = 1'b0;
    localparam logic REQ_EXTRACT = 1'b1;

    typedef struct packed {
        logic            req_type;
        logic [ID_W-1:0] song_id;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [ID_W-1:0]   result_song;
        logic [CNT_W-1:0]  result_count;
        logic [SIZE_W-1:0] heap_size;
        logic              top_valid;
        logic [ID_W-1:0]   top_song;
    } rsp_t;

    // one port of a memory as seen by the sequencer
    typedef struct packed {
        logic            we;
        logic [ID_W-1:0] addr;
    } mem_ctl_t;
endpackage

FILE: sv/pcph_ram.sv
// Single port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module pcph_ram #(
    parameter int WIDTH = 8,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: sv/play_count_priority_heap.sv
// Top level: indexed max-heap of ids keyed by play count.
//
//  channel | signals                 | payload
//  req     | req_valid / req_ready   | req_t  (req_type, song_id)
//  rsp     | rsp_valid / rsp_ready   | rsp_t  (ok .. top_song)
//
// One item at a time. Each sift-up and sift-down level goes through the
// single-ported slot, position and count memories.
// After reset a clearing pass over every id zeroes counts and positions;
// req_ready stays low during it.
// A result waits in the output register for rsp_ready; a finished item holds
// in S_DONE only while that register still holds an unaccepted result.
`timescale 1ns / 1ps
module play_count_priority_heap
    import pcph_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);
    localparam logic [4:0] S_CLR  = 5'd0,  S_IDLE = 5'd1,  S_R0 = 5'd2,
                           S_R1   = 5'd3,  S_UP0  = 5'd4,  S_UP1 = 5'd5,
                           S_UP2  = 5'd6,  S_UP3  = 5'd7,  S_X0 = 5'd8,
                           S_X1   = 5'd9,  S_X2   = 5'd10, S_X3 = 5'd11,
                           S_DN0  = 5'd12, S_DN1  = 5'd13, S_DN2 = 5'd14,
                           S_DN3  = 5'd15, S_DN4  = 5'd16,
                           S_SW0  = 5'd18, S_SW1  = 5'd19, S_TOP0 = 5'd20,
                           S_TOP1 = 5'd21, S_DONE = 5'd22;

    logic [4:0]  state_reg, state_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ID_W-1:0]   id_reg, id_next;       // item being moved
    logic [CNT_W-1:0]  key_reg, key_next;     // its count
    logic [SIZE_W-1:0] pos_reg, pos_next;     // its current slot
    logic [SIZE_W-1:0] ch_reg, ch_next;       // candidate slot
    logic [ID_W-1:0]   cid_reg, cid_next;     // candidate id
    logic [CNT_W-1:0]  ckey_reg, ckey_next;
    logic              rdone_reg, rdone_next;  // right child examined
    logic [ID_W-1:0]   top_reg, top_next;
    rsp_t              out_reg, out_next;
    rsp_t              rsp_reg, rsp_next;
    logic              ov_reg, ov_next;

    mem_ctl_t hc, pc, cc;
    logic [SLOT_W-1:0] h_wd, h_rd;
    logic [SIZE_W:0]   p_wd, p_rd;  // {present, slot}
    logic [CNT_W-1:0]  c_wd, c_rd;

    pcph_ram #(.WIDTH(SLOT_W), .ADDR_W(SLOT_W)) u_slots
        (.clk(clk), .we(hc.we), .addr(hc.addr), .wdata(h_wd), .rdata(h_rd));
    pcph_ram #(.WIDTH(SIZE_W + 1), .ADDR_W(ID_W)) u_pos
        (.clk(clk), .we(pc.we), .addr(pc.addr), .wdata(p_wd), .rdata(p_rd));
    pcph_ram #(.WIDTH(CNT_W), .ADDR_W(ID_W)) u_cnt
        (.clk(clk), .we(cc.we), .addr(cc.addr), .wdata(c_wd), .rdata(c_rd));

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = ov_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg; size_next = size_reg; id_next = id_reg;
        key_next = key_reg; pos_next = pos_reg; ch_next = ch_reg;
        cid_next = cid_reg; ckey_next = ckey_reg; rdone_next = rdone_reg;
        top_next = top_reg; out_next = out_reg; rsp_next = rsp_reg;
        ov_next = ov_reg && !rsp_ready;
        hc = '0; pc = '0; cc = '0;
        h_wd = '0; p_wd = '0; c_wd = '0;
        unique case (state_reg)
            S_CLR:
            begin
                pc.we = 1'b1; pc.addr = pos_reg[ID_W-1:0];
                cc.we = 1'b1; cc.addr = pos_reg[ID_W-1:0];
                pos_next = pos_reg + 1'b1;
                if (pos_reg[ID_W-1:0] == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    id_next = req.song_id;
                    out_next = '0;
                    if (req.req_type == REQ_RECORD)
                    begin
                        pc.addr = req.song_id; cc.addr = req.song_id;
                        state_next = S_R0;
                    end
                    else if (size_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        hc.addr = '0;
                        state_next = S_X0;
                    end
                end
            end
            S_R0:
            begin
                // count and position arrive
                out_next.result_song = id_reg;
                key_next = (c_rd == CNT_MAX) ? c_rd : c_rd + 1'b1;
                if (p_rd[SIZE_W])
                begin
                    pos_next = p_rd[SIZE_W-1:0];
                    out_next.ok = 1'b1;
                    out_next.result_count = (c_rd == CNT_MAX) ? c_rd : c_rd + 1'b1;
                    cc.we = 1'b1; cc.addr = id_reg;
                    c_wd = (c_rd == CNT_MAX) ? c_rd : c_rd + 1'b1;
                    state_next = S_UP0;
                end
                else if (size_reg == SIZE_FULL)
                begin
                    out_next.result_count = c_rd;
                    state_next = S_TOP0;
                end
                else
                begin
                    pos_next = size_reg;
                    size_next = size_reg + 1'b1;
                    out_next.ok = 1'b1;
                    out_next.result_count = (c_rd == CNT_MAX) ? c_rd : c_rd + 1'b1;
                    cc.we = 1'b1; cc.addr = id_reg;
                    c_wd = (c_rd == CNT_MAX) ? c_rd : c_rd + 1'b1;
                    state_next = S_R1;
                end
            end
            S_R1:
            begin
                hc.we = 1'b1; hc.addr = pos_reg[SLOT_W-1:0]; h_wd = id_reg;
                pc.we = 1'b1; pc.addr = id_reg; p_wd = {1'b1, pos_reg};
                state_next = S_UP0;
            end
            S_UP0:
            begin
                if (pos_reg == '0)
                begin
                    state_next = S_TOP0;
                end
                else
                begin
                    ch_next = (pos_reg - 1'b1) >> 1;
                    hc.addr = SLOT_W'((pos_reg - 1'b1) >> 1);
                    state_next = S_UP1;
                end
            end
            S_UP1:
            begin
                cid_next = h_rd; cc.addr = h_rd;
                state_next = S_UP2;
            end
            S_UP2:
            begin
                if (c_rd >= key_reg)
                begin
                    state_next = S_TOP0;
                end
                else
                begin
                    // move parent down into our slot
                    hc.we = 1'b1; hc.addr = pos_reg[SLOT_W-1:0]; h_wd = cid_reg;
                    pc.we = 1'b1; pc.addr = cid_reg; p_wd = {1'b1, pos_reg};
                    state_next = S_UP3;
                end
            end
            S_UP3:
            begin
                hc.we = 1'b1; hc.addr = ch_reg[SLOT_W-1:0]; h_wd = id_reg;
                pc.we = 1'b1; pc.addr = id_reg; p_wd = {1'b1, ch_reg};
                pos_next = ch_reg;
                state_next = S_UP0;
            end
            S_X0:
            begin
                // root id arrives; drop it from the map
                out_next.ok = 1'b1; out_next.result_song = h_rd;
                pc.we = 1'b1; pc.addr = h_rd; p_wd = '0;
                cc.addr = h_rd;
                size_next = size_reg - 1'b1;
                state_next = S_X1;
            end
            S_X1:
            begin
                out_next.result_count = c_rd;
                if (size_reg == '0)
                begin
                    state_next = S_TOP0;
                end
                else
                begin
                    hc.addr = size_reg[SLOT_W-1:0];
                    state_next = S_X2;
                end
            end
            S_X2:
            begin
                id_next = h_rd; cc.addr = h_rd;
                hc.we = 1'b1; hc.addr = '0; h_wd = h_rd;
                pc.we = 1'b1; pc.addr = h_rd; p_wd = {1'b1, {SIZE_W{1'b0}}};
                pos_next = '0;
                state_next = S_X3;
            end
            S_X3:
            begin
                key_next = c_rd;
                state_next = S_DN0;
            end
            S_DN0:
            begin
                // left child
                ch_next = pos_reg; ckey_next = key_reg; cid_next = id_reg;
                rdone_next = 1'b0;
                if ({pos_reg, 1'b1} < {1'b0, size_reg})
                begin
                    hc.addr = SLOT_W'({pos_reg, 1'b1});
                    state_next = S_DN1;
                end
                else
                begin
                    state_next = S_TOP0;
                end
            end
            S_DN1:
            begin
                // hold the left child address so its id stays on the read port
                hc.addr = SLOT_W'({pos_reg, 1'b1});
                cc.addr = h_rd;
                state_next = S_DN2;
            end
            S_DN2:
            begin
                if (c_rd > ckey_reg)
                begin
                    ckey_next = c_rd;
                    cid_next = h_rd;
                    ch_next = SIZE_W'({pos_reg, 1'b1} + rdone_reg);
                end
                if (!rdone_reg && ({pos_reg, 1'b1} + 1'b1 < {1'b0, size_reg}))
                begin
                    rdone_next = 1'b1;
                    hc.addr = SLOT_W'({pos_reg, 1'b1} + 1'b1);
                    state_next = S_DN3;
                end
                else
                begin
                    state_next = S_DN4;
                end
            end
            S_DN3:
            begin
                // hold the right child address so its id stays on the read port
                hc.addr = SLOT_W'({pos_reg, 1'b1} + 1'b1);
                cc.addr = h_rd;
                state_next = S_DN2;
            end
            S_DN4:
            begin
                if (ch_reg == pos_reg)
                begin
                    state_next = S_TOP0;
                end
                else
                begin
                    hc.we = 1'b1; hc.addr = pos_reg[SLOT_W-1:0]; h_wd = cid_reg;
                    pc.we = 1'b1; pc.addr = cid_reg; p_wd = {1'b1, pos_reg};
                    state_next = S_SW0;
                end
            end
            S_SW0:
            begin
                hc.we = 1'b1; hc.addr = ch_reg[SLOT_W-1:0]; h_wd = id_reg;
                pc.we = 1'b1; pc.addr = id_reg; p_wd = {1'b1, ch_reg};
                pos_next = ch_reg;
                state_next = S_SW1;
            end
            S_SW1:
            begin
                state_next = S_DN0;
            end
            S_TOP0:
            begin
                hc.addr = '0;
                state_next = S_TOP1;
            end
            S_TOP1:
            begin
                top_next = h_rd;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                out_next.heap_size = size_reg;
                out_next.top_valid = size_reg != '0;
                out_next.top_song = (size_reg != '0) ? top_reg : '0;
                // hold until the output register is free
                if (!ov_reg || rsp_ready)
                begin
                    rsp_next = out_next;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            size_reg  <= '0;
            pos_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            pos_reg   <= pos_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next; key_reg <= key_next; ch_reg <= ch_next;
        cid_reg <= cid_next; ckey_reg <= ckey_next; rdone_reg <= rdone_next;
        top_reg <= top_next; out_reg <= out_next; rsp_reg <= rsp_next;
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_size_cap: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg <= SIZE_FULL)
        else $error("size overflow");
    a_rsp_top: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.top_valid == (rsp.heap_size != '0))
        else $error("top_valid mismatch");
endmodule
